@@ src/deque_with_search_top_macros.svh @@
`ifndef DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define DEQUE_WITH_SEARCH_TOP_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define DQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define DQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/dqs_pkg.sv @@
package dqs_pkg;

   localparam int CMD_W  = 3;
   localparam int DATA_W = 32;
   localparam int POS_W  = 6;

   typedef enum logic [CMD_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   // where the result payload comes from
   typedef enum logic [1:0] {
      RES_PLAIN = 2'd0,
      RES_POP   = 2'd1,
      RES_MATCH = 2'd2
   } res_src_type;

   typedef struct packed {
      logic        latch;
      logic        push_front;
      logic        push_back;
      logic        pop_front;
      logic        pop_back;
      logic        scan_start;
      logic        scan_step;
      logic        res_load;
      res_src_type res_src;
      status_type  res_status;
      logic        out_load;
   } dqs_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   match;
      logic   last;
      logic   out_free;
   } dqs_stat_type;

endpackage

@@ src/dqs_if.sv @@
interface dqs_req_if
   import dqs_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [DATA_W-1:0] value_in;

   modport source (output valid, output command, output value_in, input ready);
   modport sink   (input valid, input command, input value_in, output ready);
endinterface

interface dqs_rsp_if
   import dqs_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value_out;

   modport source (output valid, output status, output position, output value_out,
                   input ready);
   modport sink   (input valid, input status, input position, input value_out,
                   output ready);
endinterface

@@ src/dqs_ram.sv @@
module dqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/dqs_ctrl.sv @@
module dqs_ctrl
   import dqs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dqs_stat_type stat,
   output dqs_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_READ = 5'b00100,
      S_SCAN = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.res_load = 1'b1;
            state_in     = S_RESP;
            case (stat.op)
               OP_PUSH_FRONT: begin
                  if (stat.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.push_front = 1'b1;
                  end
               end
               OP_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.push_back = 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  if (stat.empty) begin
                     cmd.res_status = ST_EMPTY;
                  end else begin
                     cmd.res_load  = 1'b0;
                     cmd.pop_front = 1'b1;
                     state_in      = S_READ;
                  end
               end
               OP_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.res_status = ST_EMPTY;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.pop_back = 1'b1;
                     state_in     = S_READ;
                  end
               end
               OP_SEARCH: begin
                  if (stat.empty) begin
                     cmd.res_status = ST_MISS;
                  end else begin
                     cmd.res_load   = 1'b0;
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  cmd.res_status = ST_OK;
               end
            endcase
         end
         S_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_src  = RES_POP;
            state_in     = S_RESP;
         end
         S_SCAN: begin
            if (stat.match) begin
               cmd.res_load = 1'b1;
               cmd.res_src  = RES_MATCH;
               state_in     = S_RESP;
            end else if (stat.last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_MISS;
               state_in       = S_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/dqs_datapath.sv @@
module dqs_datapath
   import dqs_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dqs_cmd_type              cmd,
   output dqs_stat_type             stat,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [DATA_W-1:0] req_value_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [POS_W-1:0]         rsp_position,
   output logic signed [DATA_W-1:0] rsp_value_out
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [SUM_W-1:0] CAP_S    = SUM_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   op_type                   op_ff, op_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   status_type               res_status_ff, res_status_in;
   logic [POS_W-1:0]         res_pos_ff, res_pos_in;
   logic signed [DATA_W-1:0] res_val_ff, res_val_in;
   logic                     out_valid_ff, out_valid_in;
   status_type               out_status_ff, out_status_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;
   logic signed [DATA_W-1:0] out_val_ff, out_val_in;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic [IDX_W-1:0]         ram_raddr;
   logic [DATA_W-1:0]        ram_rdata;

   logic [IDX_W-1:0]         front_dec, front_inc, scan_inc;
   logic [SUM_W-1:0]         back_sum, back_wrap, tail_sum, tail_wrap;
   logic [IDX_W+POS_W-1:0]   scan_pos_ext;

   dqs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (key_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ring pointer arithmetic, each wrap done with a compare and an add or subtract
   always_comb begin
      front_dec = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
      front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_W'(1);
      scan_inc  = (scan_ptr_ff == LAST_IDX) ? '0 : scan_ptr_ff + IDX_W'(1);
      back_sum  = {1'b0, front_ff} + SUM_W'(count_ff);
      back_wrap = (back_sum >= CAP_S) ? back_sum - CAP_S : back_sum;
      tail_sum  = back_sum - SUM_W'(1);
      tail_wrap = (tail_sum >= CAP_S) ? tail_sum - CAP_S : tail_sum;
      scan_pos_ext = (IDX_W + POS_W)'(scan_idx_ff);
   end

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      scan_ptr_in   = scan_ptr_ff;
      scan_idx_in   = scan_idx_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_val_in    = res_val_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_pos_in    = out_pos_ff;
      out_val_in    = out_val_ff;
      ram_we        = 1'b0;
      ram_waddr     = front_dec;

      if (cmd.latch) begin
         op_in  = op_type'(req_command);
         key_in = req_value_in;
      end

      if (cmd.push_front) begin
         ram_we    = 1'b1;
         ram_waddr = front_dec;
         front_in  = front_dec;
         count_in  = count_ff + CNT_W'(1);
      end
      if (cmd.push_back) begin
         ram_we    = 1'b1;
         ram_waddr = back_wrap[IDX_W-1:0];
         count_in  = count_ff + CNT_W'(1);
      end
      if (cmd.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.pop_back) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.scan_start) begin
         scan_ptr_in = front_inc;
         scan_idx_in = '0;
      end
      if (cmd.scan_step) begin
         scan_ptr_in = scan_inc;
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end

      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         case (cmd.res_src)
            RES_POP: begin
               res_pos_in = '0;
               res_val_in = $signed(ram_rdata);
            end
            RES_MATCH: begin
               res_pos_in = scan_pos_ext[POS_W-1:0];
               res_val_in = key_ff;
            end
            default: begin
               res_pos_in = '0;
               res_val_in = '0;
            end
         endcase
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_pos_in    = res_pos_ff;
         out_val_in    = res_val_ff;
      end
   end

   // pop back reads the tail, scan steps read the scan pointer, else the front
   always_comb begin
      if (cmd.pop_back) begin
         ram_raddr = tail_wrap[IDX_W-1:0];
      end else if (cmd.scan_step) begin
         ram_raddr = scan_ptr_ff;
      end else begin
         ram_raddr = front_ff;
      end
   end

   always_comb begin
      stat.op       = op_ff;
      stat.full     = (count_ff == CAP_C);
      stat.empty    = (count_ff == '0);
      stat.match    = (ram_rdata == key_ff);
      stat.last     = ((SUM_W'(scan_idx_ff) + SUM_W'(1)) == SUM_W'(count_ff));
      stat.out_free = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      scan_ptr_ff   <= scan_ptr_in;
      scan_idx_ff   <= scan_idx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_val_ff    <= res_val_in;
      out_status_ff <= out_status_in;
      out_pos_ff    <= out_pos_in;
      out_val_ff    <= out_val_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_position  = out_pos_ff;
   assign rsp_value_out = out_val_ff;

endmodule

@@ src/deque_with_search_top.sv @@
// items are taken one at a time: the next is accepted only after the last result
// has moved into the output register; the search rate is set by the single ram read
// port, and the scan walks one entry per cycle (up to CAPACITY)
// reset: synchronous, clears front pointer, element count, fsm and result valid;
// the ring store itself is not cleared, only live entries are ever read
module deque_with_search_top
   import dqs_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   dqs_req_if.sink    req_ch,
   dqs_rsp_if.source  rsp_ch
);

   // command and status bundles between the sequencer and the datapath
   dqs_cmd_type  ctrl_cmd;
   dqs_stat_type dp_stat;
   logic         ctrl_req_ready;

   // sequencer: idle -> exec -> (read | scan loop) -> resp -> idle
   // idle takes an item even while the last result still sits in the output
   // register; resp waits there until that register frees up
   dqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_req_ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   assign req_ch.ready = ctrl_req_ready;

   // datapath: ring store in a registered-read ram, front pointer and count,
   // scan pointer and index, result staging register and output register
   dqs_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ctrl_cmd),
      .stat          (dp_stat),
      .req_command   (req_ch.command),
      .req_value_in  (req_ch.value_in),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_status    (rsp_ch.status),
      .rsp_position  (rsp_ch.position),
      .rsp_value_out (rsp_ch.value_out)
   );

endmodule

@@ src/dqs_checker.sv @@
`include "deque_with_search_top_macros.svh"

module dqs_checker
   import dqs_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [POS_W-1:0]  rsp_position,
   input logic [DATA_W-1:0] rsp_value_out
);

   // items accepted whose result has not been taken yet
   logic [1:0] pend_ff, pend_in;
   logic       in_fire, out_fire;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (in_fire && !out_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (out_fire && !in_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `DQS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_value_out), "stalled result changed")
   `DQS_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), (rsp_position == '0) && (rsp_value_out == '0), "failed result carries data")
   `DQS_ASSERT_NOW(a_no_orphan, clock, reset, rsp_valid, pend_ff != 2'd0, "result without an item")
   `DQS_ASSERT_NOW(a_pend_bound, clock, reset, in_fire, pend_ff != 2'd2, "item taken with two pending")

endmodule

bind deque_with_search_top dqs_checker u_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_position  (rsp_ch.position),
   .rsp_value_out (rsp_ch.value_out)
);
